[sv/a32r_pkg.sv]
// Shared types and instruction encoding constants for the A32 PC-relative relocator.
package a32r_pkg;

    typedef enum logic [2:0] {
        KIND_COPY    = 3'd0,
        KIND_BRANCH  = 3'd1,
        KIND_BLINK   = 3'd2,
        KIND_LDRLIT  = 3'd3,
        KIND_ADDPC   = 3'd4,
        KIND_REFUSED = 3'd5
    } t_kind;

    typedef logic [31:0] t_word;

    localparam int unsigned MaxWords = 4;

    localparam t_word BranchMask   = 32'h0E00_0000;
    localparam t_word BranchMatch  = 32'h0A00_0000;
    localparam t_word LdrLitMask   = 32'h0F7F_0000;
    localparam t_word LdrLitMatch  = 32'h051F_0000;
    localparam t_word AddPcMask    = 32'h0FEF_0FF0;
    localparam t_word AddPcMatch   = 32'h008F_0000;
    localparam t_word HintMask     = 32'h0FF0_F000;
    localparam t_word HintMatch    = 32'h0320_F000;

    localparam t_word WordLdrPcLit = 32'h051F_F000;
    localparam t_word WordLdrIpLit = 32'h059F_C004;
    localparam t_word WordBlxIp    = 32'h012F_FF3C;
    localparam t_word WordSkip     = 32'hEA00_0000;
    localparam t_word WordLdrRdLit = 32'h059F_0000;
    localparam t_word WordLdrRdRd  = 32'h0590_0000;
    localparam t_word WordLdrIpAl  = 32'hE59F_C000;
    localparam t_word WordAddRdIp  = 32'h008C_0000;

    localparam logic [3:0] CondNever = 4'hF;
    localparam logic [3:0] RegIp     = 4'd12;
    localparam logic [3:0] RegPc     = 4'd15;

endpackage

[sv/a32r_if.sv]
// Valid/ready channel interfaces for the instruction input and the trampoline output.
interface a32r_instr_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr_word;
    logic [31:0] instr_address;

    modport source (output valid, output instr_word, output instr_address, input ready);
    modport sink   (input valid, input instr_word, input instr_address, output ready);
endinterface

interface a32r_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_word;
    logic [2:0]  rewrite_kind;
    logic        refused;
    logic        last_word;

    modport source (output valid, output out_word, output rewrite_kind, output refused,
                    output last_word, input ready);
    modport sink   (input valid, input out_word, input rewrite_kind, input refused,
                    input last_word, output ready);
endinterface

[sv/a32_pc_relative_relocator.sv]
// Top level of the A32 PC-relative relocator that builds inline-hook trampoline words.
//
//   channel    direction  word contents
//   i_instr    in         instr_word, instr_address
//   o_result   out        out_word, rewrite_kind, refused, last_word
//
// An accepted instruction is decoded in the cycle it is taken, and its whole expansion
// (one to four words) lands in the word buffer at the next edge. The buffer drains one
// word per cycle while ready is high, so an instruction holds the output channel for
// one, three or four words; the output port sets the rate. A new instruction is taken
// in the cycle the last word of the previous one leaves, so there is no bubble. Reset
// clears only the busy flag and the word index; a stalled output holds the current word.
module a32_pc_relative_relocator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    a32r_instr_if.sink           i_instr,
    a32r_result_if.source        o_result
);
    import a32r_pkg::*;

    // Word buffer holding the expansion of one instruction.
    t_word       r_words [MaxWords];
    t_word       n_words [MaxWords];
    t_kind       r_kind;
    t_kind       n_kind;
    logic [1:0]  r_last;
    logic [1:0]  n_last;
    logic [1:0]  r_idx;
    logic        r_busy;

    logic        in_fire;
    logic        out_fire;
    logic        at_last;

    // Decode signals.
    t_word       w;
    t_word       pc;
    t_word       off;
    t_word       tgt;
    t_word       lit;
    logic [3:0]  cond;
    logic [3:0]  rn;
    logic [3:0]  rd;
    logic [3:0]  rs;
    logic [3:0]  rm;
    logic        pc_use;

    assign at_last  = (r_idx == r_last);
    assign out_fire = o_result.valid && o_result.ready;
    assign i_instr.ready = !r_busy || (out_fire && at_last);
    assign in_fire  = i_instr.valid && i_instr.ready;

    assign o_result.valid        = r_busy;
    assign o_result.out_word     = r_words[r_idx];
    assign o_result.rewrite_kind = r_kind;
    assign o_result.refused      = (r_kind == KIND_REFUSED);
    assign o_result.last_word    = at_last;

    assign w    = i_instr.instr_word;
    assign pc   = i_instr.instr_address + 32'd8;
    assign cond = w[31:28];
    assign rn   = w[19:16];
    assign rd   = w[15:12];
    assign rs   = w[11:8];
    assign rm   = w[3:0];
    // Branch offset is a word count, sign extended from 24 bits.
    assign off  = {{6{w[23]}}, w[23:0], 2'b00};
    assign tgt  = pc + off;
    assign lit  = w[23] ? (pc + {20'd0, w[11:0]}) : (pc - {20'd0, w[11:0]});

    // Generic PC-use check, split by the two top encoding class bits.
    always_comb begin
        pc_use = 1'b0;
        if ((w & HintMask) != HintMatch) begin
            case (w[27:26])
                2'd0: begin
                    pc_use = (rn == RegPc) || (rd == RegPc)
                           || (!w[25] && (rm == RegPc))
                           || (!w[25] && !w[7] && w[4] && (rs == RegPc));
                end
                2'd1: begin
                    pc_use = (rn == RegPc) || (rd == RegPc) || (w[25] && (rm == RegPc));
                end
                2'd2: begin
                    pc_use = !w[25] && ((rn == RegPc) || w[15]);
                end
                default: begin
                    pc_use = (rn == RegPc);
                end
            endcase
        end
    end

    // Build the full expansion of the incoming instruction.
    always_comb begin
        for (int i = 0; i < MaxWords; i++) begin
            n_words[i] = '0;
        end
        n_kind = KIND_REFUSED;
        n_last = 2'd0;
        if ((w & BranchMask) == BranchMatch) begin
            if (cond == CondNever) begin
                n_kind = KIND_REFUSED;
            end else if (w[24]) begin
                n_kind     = KIND_BLINK;
                n_last     = 2'd3;
                n_words[0] = {cond, 28'd0} | WordLdrIpLit;
                n_words[1] = {cond, 28'd0} | WordBlxIp;
                n_words[2] = WordSkip;
                n_words[3] = tgt;
            end else begin
                n_kind     = KIND_BRANCH;
                n_last     = 2'd2;
                n_words[0] = {cond, 28'd0} | WordLdrPcLit;
                n_words[1] = WordSkip;
                n_words[2] = tgt;
            end
        end else if ((w & LdrLitMask) == LdrLitMatch) begin
            if ((cond == CondNever) || (rd == RegPc)) begin
                n_kind = KIND_REFUSED;
            end else begin
                n_kind     = KIND_LDRLIT;
                n_last     = 2'd3;
                n_words[0] = {cond, 28'd0} | WordLdrRdLit | {16'd0, rd, 12'd0};
                n_words[1] = WordSkip;
                n_words[2] = lit;
                n_words[3] = {cond, 28'd0} | WordLdrRdRd | {12'd0, rd, rd, 12'd0};
            end
        end else if (((w & AddPcMask) == AddPcMatch) && (rd != RegPc)) begin
            if ((cond == CondNever) || (rd == RegIp) || (rm == RegIp) || (rm == RegPc)) begin
                n_kind = KIND_REFUSED;
            end else begin
                n_kind     = KIND_ADDPC;
                n_last     = 2'd3;
                n_words[0] = WordLdrIpAl;
                n_words[1] = WordSkip;
                n_words[2] = pc;
                // The S bit of the original add is carried over.
                n_words[3] = {cond, 28'd0} | WordAddRdIp | {11'd0, w[20], 4'd0, rd, 8'd0, rm};
            end
        end else if (pc_use) begin
            n_kind = KIND_REFUSED;
        end else begin
            n_kind     = KIND_COPY;
            n_words[0] = w;
        end
    end

    // Control: busy flag and the index of the word on the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (in_fire) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (out_fire) begin
            if (at_last) begin
                r_busy <= 1'b0;
                r_idx  <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // Payload of the word buffer, loaded only when an instruction is taken.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_words <= n_words;
            r_kind  <= n_kind;
            r_last  <= n_last;
        end
    end

endmodule

[tb/sv/tb_a32_pc_relative_relocator.sv]
// Self-checking testbench for the A32 PC-relative relocator: directed probes, then random traffic.
module tb_a32_pc_relative_relocator;
    import a32r_pkg::*;

    localparam int NumRandom  = 205;
    localparam int QuietTail  = 40;      // random items at the end with no idling on either side
    localparam int DrainWait  = 8;       // cycles kept open after the last expected word arrives
    localparam int CycleLimit = 200000;  // watchdog limit, far above the slowest legal run

    // One trampoline word as it should appear on the result channel.
    typedef struct {
        t_word out_word;
        t_kind kind;
        logic  refused;
        logic  last_word;
    } t_result;

    // One directed probe. When is_typed is set, the expected single word is written
    // here by hand (a copy of the instruction or a refusal); otherwise the predictor
    // computes the expansion.
    typedef struct {
        t_word word;
        t_word addr;
        logic  is_typed;
        t_kind kind;
    } t_probe;

    localparam int NumProbes = 25;

    t_probe probes [NumProbes] = '{
        '{32'hEA00_0000, 32'h0000_0000, 1'b0, KIND_COPY},    // B +0 from address zero
        '{32'h0A7F_FFFF, 32'hFFFF_FFF8, 1'b0, KIND_COPY},    // BEQ, largest forward offset
        '{32'hEA80_0000, 32'h0000_0000, 1'b0, KIND_COPY},    // B, largest backward offset
        '{32'hEBFF_FFFF, 32'h0000_1000, 1'b0, KIND_COPY},    // BL -4
        '{32'h1B00_0010, 32'h0000_8000, 1'b0, KIND_COPY},    // BLNE forward
        '{32'hFA00_0000, 32'h0000_0000, 1'b1, KIND_REFUSED}, // BLX immediate, changes state
        '{32'hFB12_3456, 32'h0000_0100, 1'b1, KIND_REFUSED}, // BLX immediate with H bit
        '{32'hE59F_0FFF, 32'h0000_0000, 1'b0, KIND_COPY},    // LDR r0,[pc,#4095]
        '{32'hE51F_3000, 32'hFFFF_FFFC, 1'b0, KIND_COPY},    // LDR r3,[pc,#-0], literal wraps
        '{32'h151F_CFFF, 32'h0000_0004, 1'b0, KIND_COPY},    // LDRNE ip,[pc,#-4095], wraps
        '{32'hE59F_F004, 32'h0000_2000, 1'b1, KIND_REFUSED}, // literal load into PC
        '{32'hF59F_0004, 32'h0000_2000, 1'b1, KIND_REFUSED}, // literal load pattern, never cond
        '{32'hE08F_0001, 32'h0000_3000, 1'b0, KIND_COPY},    // ADD r0,pc,r1
        '{32'h409F_E000, 32'hFFFF_FFF8, 1'b0, KIND_COPY},    // ADDSMI lr,pc,r0 keeps S
        '{32'hE08F_C001, 32'h0000_3000, 1'b1, KIND_REFUSED}, // ADD with ip as destination
        '{32'hE08F_100C, 32'h0000_3000, 1'b1, KIND_REFUSED}, // ADD with ip as source
        '{32'hE08F_100F, 32'h0000_3000, 1'b1, KIND_REFUSED}, // ADD reading PC twice
        '{32'hE08F_F001, 32'h0000_3000, 1'b1, KIND_REFUSED}, // ADD writing PC
        '{32'hF08F_0001, 32'h0000_3000, 1'b1, KIND_REFUSED}, // ADD pc pattern, never cond
        '{32'hE320_F000, 32'h0000_4000, 1'b1, KIND_COPY},    // NOP from the hint space
        '{32'hE1A0_0001, 32'h0000_4004, 1'b1, KIND_COPY},    // MOV r0,r1
        '{32'hE8BD_8000, 32'h0000_4008, 1'b1, KIND_REFUSED}, // POP {pc}, PC in register list
        '{32'hE1A0_F00E, 32'h0000_400C, 1'b1, KIND_REFUSED}, // MOV pc,lr
        '{32'h0000_0000, 32'h0000_0000, 1'b1, KIND_COPY},    // all zeros
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, KIND_REFUSED}  // all ones, odd address
    };

    logic i_clk;
    logic i_rst_n;

    a32r_instr_if  instr_ch ();
    a32r_result_if result_ch ();

    a32_pc_relative_relocator uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_instr  (instr_ch),
        .o_result (result_ch)
    );

    // Expected trampoline words, oldest first.
    t_result pending_words [$];

    int failures      = 0;
    int words_checked = 0;
    int instrs_sent   = 0;
    int kind_count [6] = '{default: 0};
    int cycle_count   = 0;
    bit idling        = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Reset is asserted at the start and never asserted again.
    initial begin
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // The watchdog ends a run that hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("[a32_pc_relative_relocator] ERROR");
            $finish;
        end
    end

    function automatic void push_word(input t_word word, input t_kind kind, input logic last);
        pending_words.push_back('{word, kind, kind == KIND_REFUSED, last});
        if (last) kind_count[kind]++;
    endfunction

    // Per-class check for any remaining register field or list bit that names PC.
    function automatic logic reads_pc(input t_word w);
        logic [3:0] rn;
        logic [3:0] rd;
        logic [3:0] rs;
        logic [3:0] rm;
        rn = w[19:16];
        rd = w[15:12];
        rs = w[11:8];
        rm = w[3:0];
        if ((w & HintMask) == HintMatch) return 1'b0;
        case (w[27:26])
            2'd0: begin
                if (rn == RegPc || rd == RegPc) return 1'b1;
                if (!w[25]) begin
                    if (rm == RegPc) return 1'b1;
                    // Register-shifted register form: Rs is read too.
                    if (!w[7] && w[4] && rs == RegPc) return 1'b1;
                end
                return 1'b0;
            end
            2'd1: return rn == RegPc || rd == RegPc || (w[25] && rm == RegPc);
            2'd2: return !w[25] && (rn == RegPc || w[15]);
            default: return rn == RegPc;
        endcase
    endfunction

    // Works out the trampoline words for one instruction and queues them.
    function automatic void predict_trampoline(input t_word w, input t_word addr);
        t_word      pc;
        t_word      cbits;
        t_word      target;
        t_word      literal;
        logic [3:0] cond;
        logic [3:0] rd;
        logic [3:0] rm;
        pc    = addr + 32'd8;
        cond  = w[31:28];
        cbits = {cond, 28'd0};
        rd    = w[15:12];
        rm    = w[3:0];
        if ((w & BranchMask) == BranchMatch) begin
            target = pc + {{6{w[23]}}, w[23:0], 2'b00};
            if (cond == CondNever) begin
                push_word('0, KIND_REFUSED, 1'b1);
            end else if (w[24]) begin
                push_word(cbits | WordLdrIpLit, KIND_BLINK, 1'b0);
                push_word(cbits | WordBlxIp, KIND_BLINK, 1'b0);
                push_word(WordSkip, KIND_BLINK, 1'b0);
                push_word(target, KIND_BLINK, 1'b1);
            end else begin
                push_word(cbits | WordLdrPcLit, KIND_BRANCH, 1'b0);
                push_word(WordSkip, KIND_BRANCH, 1'b0);
                push_word(target, KIND_BRANCH, 1'b1);
            end
        end else if ((w & LdrLitMask) == LdrLitMatch) begin
            literal = w[23] ? pc + {20'd0, w[11:0]} : pc - {20'd0, w[11:0]};
            if (cond == CondNever || rd == RegPc) begin
                push_word('0, KIND_REFUSED, 1'b1);
            end else begin
                push_word(cbits | WordLdrRdLit | {16'd0, rd, 12'd0}, KIND_LDRLIT, 1'b0);
                push_word(WordSkip, KIND_LDRLIT, 1'b0);
                push_word(literal, KIND_LDRLIT, 1'b0);
                push_word(cbits | WordLdrRdRd | {12'd0, rd, rd, 12'd0}, KIND_LDRLIT, 1'b1);
            end
        end else if ((w & AddPcMask) == AddPcMatch && rd != RegPc) begin
            if (cond == CondNever || rd == RegIp || rm == RegIp || rm == RegPc) begin
                push_word('0, KIND_REFUSED, 1'b1);
            end else begin
                push_word(WordLdrIpAl, KIND_ADDPC, 1'b0);
                push_word(WordSkip, KIND_ADDPC, 1'b0);
                push_word(pc, KIND_ADDPC, 1'b0);
                push_word(cbits | WordAddRdIp | {11'd0, w[20], 4'd0, rd, 8'd0, rm},
                          KIND_ADDPC, 1'b1);
            end
        end else if (reads_pc(w)) begin
            push_word('0, KIND_REFUSED, 1'b1);
        end else begin
            push_word(w, KIND_COPY, 1'b1);
        end
    endfunction

    // Random instructions lean toward the rewritten forms so that every expansion is
    // exercised with random content; the rest is hint-space words, PC-field noise and raw words.
    function automatic t_word random_instr();
        t_word      w;
        logic [3:0] cond;
        w    = $urandom;
        cond = ($urandom_range(0, 15) == 0) ? CondNever : 4'($urandom_range(0, 14));
        case ($urandom_range(0, 9))
            0, 1: w = {cond, 3'b101, w[24:0]};
            2, 3: w = {cond, 4'b0101, w[23], 3'b001, 4'hF, w[15:0]};
            4, 5: w = {cond, 7'b0000100, w[20], 4'hF, w[15:12], 8'h00, w[3:0]};
            6:    w = {cond, 8'h32, w[19:16], 4'hF, w[11:0]};
            7: begin
                case ($urandom_range(0, 3))
                    0: w[19:16] = RegPc;
                    1: w[15:12] = RegPc;
                    2: w[11:8]  = RegPc;
                    default: w[3:0] = RegPc;
                endcase
            end
            default: ;
        endcase
        return w;
    endfunction

    function automatic t_word random_address();
        case ($urandom_range(0, 7))
            0: return 32'hFFFF_FFF0 | ($urandom & 32'h0000_000C);
            1: return $urandom;
            default: return $urandom & 32'hFFFF_FFFC;
        endcase
    endfunction

    // Presents one instruction word and returns at the edge that takes it. The caller
    // is at a rising edge, so valid is raised here without first being lowered.
    task automatic send_instr(input t_word w, input t_word addr);
        instr_ch.valid         <= 1'b1;
        instr_ch.instr_word    <= w;
        instr_ch.instr_address <= addr;
        @(negedge i_clk);
        while (!instr_ch.ready) @(negedge i_clk);
        @(posedge i_clk);
        instrs_sent++;
    endtask

    task automatic sender_gap();
        if (idling && $urandom_range(0, 3) == 0) begin
            instr_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // The result side stalls in random bursts while idling is on.
    initial begin
        result_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (idling && $urandom_range(0, 5) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                result_ch.ready <= 1'b1;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Words are sampled at the falling edge, where valid and ready hold the values
    // that the next rising edge will act on.
    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            words_checked++;
            if (pending_words.size() == 0) begin
                $error("unexpected result word %h", result_ch.out_word);
                failures++;
            end else begin
                want = pending_words.pop_front();
                if (result_ch.out_word !== want.out_word) begin
                    $error("out_word: expected %h, actual %h", want.out_word, result_ch.out_word);
                    failures++;
                end
                if (result_ch.rewrite_kind !== want.kind) begin
                    $error("rewrite_kind: expected %0d, actual %0d",
                           want.kind, result_ch.rewrite_kind);
                    failures++;
                end
                if (result_ch.refused !== want.refused) begin
                    $error("refused: expected %0b, actual %0b", want.refused, result_ch.refused);
                    failures++;
                end
                if (result_ch.last_word !== want.last_word) begin
                    $error("last_word: expected %0b, actual %0b",
                           want.last_word, result_ch.last_word);
                    failures++;
                end
            end
        end
    end

    initial begin
        t_word w;
        t_word addr;
        instr_ch.valid         <= 1'b0;
        instr_ch.instr_word    <= '0;
        instr_ch.instr_address <= '0;
        while (!i_rst_n) @(posedge i_clk);
        @(posedge i_clk);

        // Directed probes: extremes of the offset and immediate fields, every rewrite,
        // and each refusal rule.
        for (int i = 0; i < NumProbes; i++) begin
            sender_gap();
            if (probes[i].is_typed) begin
                push_word(probes[i].kind == KIND_COPY ? probes[i].word : '0,
                          probes[i].kind, 1'b1);
            end else begin
                predict_trampoline(probes[i].word, probes[i].addr);
            end
            send_instr(probes[i].word, probes[i].addr);
        end

        for (int n = 0; n < NumRandom; n++) begin
            if (n == NumRandom - QuietTail) idling = 1'b0;
            if (n == NumRandom / 2) begin
                // Let the output side run completely dry once before going on.
                instr_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (pending_words.size() != 0) @(posedge i_clk);
            end else begin
                sender_gap();
            end
            w    = random_instr();
            addr = random_address();
            predict_trampoline(w, addr);
            send_instr(w, addr);
        end

        instr_ch.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);

        $display("Relocated %0d instructions into %0d trampoline words, directed and random.",
                 instrs_sent, words_checked);
        $display("Per kind: copy %0d, branch %0d, branch-link %0d, literal load %0d,",
                 kind_count[KIND_COPY], kind_count[KIND_BRANCH], kind_count[KIND_BLINK],
                 kind_count[KIND_LDRLIT]);
        $display("          add %0d, refused %0d.",
                 kind_count[KIND_ADDPC], kind_count[KIND_REFUSED]);
        if (failures == 0 && pending_words.size() == 0) begin
            $display("[a32_pc_relative_relocator] OK");
        end else begin
            $display("[a32_pc_relative_relocator] ERROR");
        end
        $finish;
    end

endmodule
